// ===== design/gs3_pkg.sv =====
// Shared constants, types and helpers for the 3x3 binomial smoothing block.
`timescale 1ns / 1ps
`default_nettype none

package gs3_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int MIN_DIM       = 3;
   localparam int ADDR_BITS     = $clog2(MAX_WIDTH);
   localparam int DIM_BITS      = 11;
   localparam int COL_BITS      = DIM_BITS;
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
   localparam int CSUM_BITS     = SAMPLE_BITS + 2;
   localparam int SUM_BITS      = SAMPLE_BITS + 4;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [DIM_BITS-1:0]    dim_type;

   // One window column: the sample two rows up, one row up and the current row.
   typedef struct packed {
      sample_type top;
      sample_type mid;
      sample_type bot;
   } column_type;

   typedef struct packed {
      sample_type upper;
      sample_type lower;
   } row_pair_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr_a;
      logic [ADDR_BITS-1:0] addr_b;
   } lb_read_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      row_pair_type         data;
   } lb_write_type;

   // Vertical 1-2-1 weighting of one column.
   function automatic logic [CSUM_BITS-1:0] col_sum_f(input column_type col);
      col_sum_f = CSUM_BITS'(col.top) + (CSUM_BITS'(col.mid) << 1) + CSUM_BITS'(col.bot);
   endfunction

   // Hold a written dimension in the legal range.
   function automatic dim_type clamp_dim_f(input dim_type value, input dim_type hi);
      if (value < DIM_BITS'(MIN_DIM)) begin
         clamp_dim_f = DIM_BITS'(MIN_DIM);
      end else if (value > hi) begin
         clamp_dim_f = hi;
      end else begin
         clamp_dim_f = value;
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/gs3_if.sv =====
// Request and response channel interfaces of the smoothing block.
`timescale 1ns / 1ps
`default_nettype none

interface gs3_req_if;
   import gs3_pkg::*;

   logic       valid;
   logic       ready;
   logic       command;
   sample_type sample;

   modport source (output valid, output command, output sample, input ready);
   modport sink (input valid, input command, input sample, output ready);
endinterface

interface gs3_rsp_if;
   import gs3_pkg::*;

   logic       valid;
   logic       ready;
   sample_type smoothed;
   logic       last_of_image;

   modport source (output valid, output smoothed, output last_of_image, input ready);
   modport sink (input valid, input smoothed, input last_of_image, output ready);
endinterface

`default_nettype wire

// ===== design/gs3_cell.sv =====
// Window cell: holds one three-sample column and passes it to its neighbor.
`timescale 1ns / 1ps
`default_nettype none

module gs3_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift,
   input  gs3_pkg::column_type                  col_in,
   output gs3_pkg::column_type                  col_out,
   output logic [gs3_pkg::CSUM_BITS-1:0]        col_sum
);
   import gs3_pkg::*;

   column_type col_ff;
   column_type col_next_in;

   always_comb begin
      col_next_in = shift ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_next_in;
      end
   end

   assign col_out = col_ff;
   assign col_sum = col_sum_f(col_ff);

endmodule

`default_nettype wire

// ===== design/gs3_line_buffer.sv =====
// Two-row line store with two registered read ports and write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module gs3_line_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  gs3_pkg::lb_read_type  rd,
   input  gs3_pkg::lb_write_type wr,
   output gs3_pkg::row_pair_type data_a,
   output gs3_pkg::row_pair_type data_b
);
   import gs3_pkg::*;

   row_pair_type row_mem [MAX_WIDTH];
   row_pair_type rd_a_ff;
   row_pair_type rd_b_ff;
   row_pair_type fwd_ff;
   logic         hit_a_ff;
   logic         hit_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         row_mem[wr.addr] <= wr.data;
      end
   end

   // The array read returns the old word when the same entry is written
   // at this edge: capture the new word and select it afterwards.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else if (rd.en) begin
         hit_a_ff <= wr.en && (wr.addr == rd.addr_a);
         hit_b_ff <= wr.en && (wr.addr == rd.addr_b);
      end
      if (rd.en) begin
         rd_a_ff <= row_mem[rd.addr_a];
         rd_b_ff <= row_mem[rd.addr_b];
         fwd_ff  <= wr.data;
      end
   end

   assign data_a = hit_a_ff ? fwd_ff : rd_a_ff;
   assign data_b = hit_b_ff ? fwd_ff : rd_b_ff;

endmodule

`default_nettype wire

// ===== design/gaussian_smooth_3x3_raster.sv =====
// Top level: raster 3x3 binomial smoothing with line store and window cells.
// A request is registered in the second stage, and its result in the output register.
// Throughput: one request per cycle unless the output stalls, set by one line-store
// access and one filter add per request; output lags input by one row plus one sample.
// Reset: synchronous; clears counters, window and stage valids, sets both
// dimensions to 256. The line store is not cleared and has no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_smooth_3x3_raster (
   input  logic                                clock,
   input  logic                                reset,
   gs3_req_if.sink                             req_chan,
   gs3_rsp_if.source                           rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gs3_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [gs3_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [gs3_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);
   import gs3_pkg::*;

   typedef enum logic [1:0] {
      SEL_PREV_UPPER,
      SEL_PREV_LOWER,
      SEL_FILTER,
      SEL_WINDOW
   } sel_type;

   // Configuration
   dim_type width_ff, width_in;
   dim_type height_ff, height_in;
   logic    csr_index;
   logic    csr_write;

   // Position state
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                tail_ff, tail_in;

   // Second stage
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_drain_ff, s1_drain_in;
   logic                 s1_emit_ff, s1_emit_in;
   logic                 s1_last_ff, s1_last_in;
   sel_type              s1_sel_ff, s1_sel_in;
   sample_type           s1_sample_ff, s1_sample_in;
   logic [ADDR_BITS-1:0] s1_addr_ff, s1_addr_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_smoothed_ff, rsp_smoothed_in;
   logic       rsp_last_ff, rsp_last_in;

   logic accept;
   logic is_drain;
   logic out_free;
   logic s1_adv;

   dim_type             width_m1;
   logic [COL_BITS-1:0] col_eff;
   logic [ROW_BITS-1:0] row_eff;
   logic [COL_BITS-1:0] col_cl;
   logic [COL_BITS-1:0] col_nx;
   logic [DIM_BITS-1:0] row_nx;
   logic [COL_BITS-1:0] drain_k;
   logic [COL_BITS-1:0] drain_addr;
   logic                drain_last;

   lb_read_type  lb_rd;
   lb_write_type lb_wr;
   row_pair_type data_a;
   row_pair_type data_b;

   column_type                col_cur;
   column_type                col_new;
   column_type                col_old;
   logic [CSUM_BITS-1:0]      sum_new;
   logic [CSUM_BITS-1:0]      sum_old;
   logic [SUM_BITS-1:0]       filt_sum;
   sample_type                s1_value;

   // Handshake
   assign accept   = req_chan.valid && req_chan.ready;
   assign is_drain = (req_chan.command == CMD_DRAIN);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv   = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_adv;

   // Configuration port
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_BITS-1];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_WIDTH:  prdata = CSR_DATA_BITS'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_BITS'(height_ff);
         default:    prdata = '0;
      endcase
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_WIDTH:  width_in  = clamp_dim_f(pwdata[DIM_BITS-1:0], DIM_BITS'(MAX_WIDTH));
            REG_HEIGHT: height_in = clamp_dim_f(pwdata[DIM_BITS-1:0], DIM_BITS'(MAX_HEIGHT));
            default: ;
         endcase
      end
   end

   // Position decode for the incoming request
   always_comb begin
      width_m1   = width_ff - DIM_BITS'(1);
      col_eff    = tail_ff ? '0 : col_ff;
      row_eff    = tail_ff ? '0 : row_ff;
      col_cl     = (col_eff >= width_ff) ? width_m1 : col_eff;
      col_nx     = col_cl + COL_BITS'(1);
      row_nx     = DIM_BITS'(row_eff) + DIM_BITS'(1);
      drain_k    = (col_ff > width_ff) ? width_ff : col_ff;
      drain_addr = drain_k - COL_BITS'(1);
      drain_last = (col_ff >= width_ff);
   end

   always_comb begin
      lb_rd.en     = accept;
      lb_rd.addr_a = col_cl[ADDR_BITS-1:0];
      lb_rd.addr_b = (is_drain && (col_ff != '0)) ? drain_addr[ADDR_BITS-1:0]
                                                  : width_m1[ADDR_BITS-1:0];
   end

   // Counters and stage loading
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      tail_in      = tail_ff;
      s1_drain_in  = s1_drain_ff;
      s1_emit_in   = s1_emit_ff;
      s1_last_in   = s1_last_ff;
      s1_sel_in    = s1_sel_ff;
      s1_sample_in = s1_sample_ff;
      s1_addr_in   = s1_addr_ff;

      if (accept) begin
         s1_valid_in = !is_drain || tail_ff;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (accept) begin
         s1_drain_in  = is_drain;
         s1_sample_in = req_chan.sample;
         s1_addr_in   = col_cl[ADDR_BITS-1:0];
         if (is_drain) begin
            s1_emit_in = 1'b1;
            s1_last_in = drain_last;
            s1_sel_in  = (col_ff == '0) ? SEL_PREV_UPPER : SEL_PREV_LOWER;
            // Ignore a drain when nothing is pending
            if (tail_ff) begin
               if (drain_last) begin
                  col_in  = '0;
                  row_in  = '0;
                  tail_in = 1'b0;
               end else begin
                  col_in = col_ff + COL_BITS'(1);
               end
            end
         end else begin
            s1_emit_in = (row_eff >= ROW_BITS'(2)) ||
                         ((row_eff == ROW_BITS'(1)) && (col_cl >= COL_BITS'(1)));
            s1_last_in = 1'b0;
            if (col_cl == '0) begin
               s1_sel_in = SEL_PREV_UPPER;
            end else if ((row_eff >= ROW_BITS'(2)) && (col_cl >= COL_BITS'(2))) begin
               s1_sel_in = SEL_FILTER;
            end else begin
               s1_sel_in = SEL_WINDOW;
            end
            // A sample during a pending tail drops the tail and starts over
            tail_in = 1'b0;
            if (col_nx >= width_ff) begin
               col_in = '0;
               if (row_nx >= height_ff) begin
                  row_in  = '0;
                  tail_in = 1'b1;
               end else begin
                  row_in = row_nx[ROW_BITS-1:0];
               end
            end else begin
               col_in = col_nx;
               row_in = row_eff;
            end
         end
      end
   end

   gs3_line_buffer u_line_buffer (
      .clock  (clock),
      .reset  (reset),
      .rd     (lb_rd),
      .wr     (lb_wr),
      .data_a (data_a),
      .data_b (data_b)
   );

   // Second stage: window, filter and line store write-back
   always_comb begin
      col_cur.top = data_a.upper;
      col_cur.mid = data_a.lower;
      col_cur.bot = s1_sample_ff;

      lb_wr.en         = s1_adv && !s1_drain_ff;
      lb_wr.addr       = s1_addr_ff;
      lb_wr.data.upper = data_a.lower;
      lb_wr.data.lower = s1_sample_ff;
   end

   gs3_cell u_cell_new (
      .clock   (clock),
      .reset   (reset),
      .shift   (lb_wr.en),
      .col_in  (col_cur),
      .col_out (col_new),
      .col_sum (sum_new)
   );

   gs3_cell u_cell_old (
      .clock   (clock),
      .reset   (reset),
      .shift   (lb_wr.en),
      .col_in  (col_new),
      .col_out (col_old),
      .col_sum (sum_old)
   );

   always_comb begin
      filt_sum = SUM_BITS'(sum_old) + (SUM_BITS'(sum_new) << 1) +
                 SUM_BITS'(col_sum_f(col_cur));
      case (s1_sel_ff)
         SEL_PREV_UPPER: s1_value = data_b.upper;
         SEL_PREV_LOWER: s1_value = data_b.lower;
         SEL_FILTER:     s1_value = filt_sum[SUM_BITS-1:4];
         SEL_WINDOW:     s1_value = col_new.mid;
         default:        s1_value = col_new.mid;
      endcase
   end

   // Output register
   always_comb begin
      rsp_smoothed_in = rsp_smoothed_ff;
      rsp_last_in     = rsp_last_ff;
      if (s1_adv && s1_emit_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_smoothed_in = s1_value;
         rsp_last_in     = s1_last_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_BITS'(256);
         height_ff    <= DIM_BITS'(256);
         col_ff       <= '0;
         row_ff       <= '0;
         tail_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         tail_ff      <= tail_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_drain_ff     <= s1_drain_in;
      s1_emit_ff      <= s1_emit_in;
      s1_last_ff      <= s1_last_in;
      s1_sel_ff       <= s1_sel_in;
      s1_sample_ff    <= s1_sample_in;
      s1_addr_ff      <= s1_addr_in;
      rsp_smoothed_ff <= rsp_smoothed_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.smoothed      = rsp_smoothed_ff;
   assign rsp_chan.last_of_image = rsp_last_ff;

`ifndef SYNTHESIS
   a_tail_row_zero: assert property (@(posedge clock) disable iff (reset)
      tail_ff |-> (row_ff == '0))
      else $error("row counter not zero while tail pending");

   a_tail_set_by_sample: assert property (@(posedge clock) disable iff (reset)
      $rose(tail_ff) |-> $past(accept && !is_drain))
      else $error("tail became pending without a sample request");

   a_last_drain_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && is_drain && tail_ff && drain_last) |=> (!tail_ff && (col_ff == '0)))
      else $error("final drain did not restart the image");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && s1_emit_ff && rsp_valid_ff))
      else $error("request stalled without a blocked result");
`endif

endmodule

`default_nettype wire
